// ===== src/channel_mask_pixel_converter_assert.svh =====
// Assertion macros shared by the channel mask pixel converter RTL.
`ifndef CHANNEL_MASK_PIXEL_CONVERTER_ASSERT_SVH
`define CHANNEL_MASK_PIXEL_CONVERTER_ASSERT_SVH

// same-cycle implication
`define CMPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cmpc_pkg.sv =====
// Types, constants and mask decode function for the channel mask pixel converter.
package cmpc_pkg;

  localparam int NUM_CHAN   = 4;
  localparam int CHAN_ALPHA = 3;
  localparam int FULL_WIDTH = 8;
  localparam logic [31:0] ALPHA_MAX = 32'd255;

  localparam logic [31:0] DEF_MASK_RED   = 32'h0000_00FF;
  localparam logic [31:0] DEF_MASK_GREEN = 32'h0000_FF00;
  localparam logic [31:0] DEF_MASK_BLUE  = 32'h00FF_0000;
  localparam logic [31:0] DEF_MASK_ALPHA = 32'hFF00_0000;

  typedef enum logic [2:0] {
    REG_SRC_RED   = 3'd0,
    REG_SRC_GREEN = 3'd1,
    REG_SRC_BLUE  = 3'd2,
    REG_SRC_ALPHA = 3'd3,
    REG_DST_RED   = 3'd4,
    REG_DST_GREEN = 3'd5,
    REG_DST_BLUE  = 3'd6,
    REG_DST_ALPHA = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [4:0] pos;
    logic [3:0] shortfall;
  } chan_shift_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][31:0] src_mask;
    chan_shift_t [NUM_CHAN-1:0] src;
    chan_shift_t [NUM_CHAN-1:0] dst;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][31:0] chan;
    logic                      mode;
  } ext_t;

  // lowest set bit and 8 minus the set span, saturated
  function automatic chan_shift_t mask_decode(input logic [31:0] m);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [5:0] span;
    chan_shift_t r;
    lo = '0;
    hi = '0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) lo = 5'(i);
    end
    for (int i = 0; i < 32; i++) begin
      if (m[i]) hi = 5'(i);
    end
    span = {1'b0, hi} - {1'b0, lo} + 6'd1;
    r.pos = lo;
    if (m == '0) begin
      r.shortfall = 4'(FULL_WIDTH);
    end else if (span >= 6'(FULL_WIDTH)) begin
      r.shortfall = '0;
    end else begin
      r.shortfall = 4'(6'(FULL_WIDTH) - span);
    end
    return r;
  endfunction

endpackage

// ===== src/cmpc_cfg.sv =====
// Mask registers, decoded to positions and shortfalls as they are written.
module cmpc_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  cmpc_pkg::reg_index_t   cfg_index,
  input  logic [31:0]            cfg_data,
  output cmpc_pkg::cfg_t         cfg
);
  import cmpc_pkg::*;

  chan_shift_t wr_shift;

  assign wr_shift = mask_decode(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_mask[0] <= DEF_MASK_RED;
      cfg.src_mask[1] <= DEF_MASK_GREEN;
      cfg.src_mask[2] <= DEF_MASK_BLUE;
      cfg.src_mask[3] <= DEF_MASK_ALPHA;
      cfg.src[0]      <= mask_decode(DEF_MASK_RED);
      cfg.src[1]      <= mask_decode(DEF_MASK_GREEN);
      cfg.src[2]      <= mask_decode(DEF_MASK_BLUE);
      cfg.src[3]      <= mask_decode(DEF_MASK_ALPHA);
      cfg.dst[0]      <= mask_decode(DEF_MASK_RED);
      cfg.dst[1]      <= mask_decode(DEF_MASK_GREEN);
      cfg.dst[2]      <= mask_decode(DEF_MASK_BLUE);
      cfg.dst[3]      <= mask_decode(DEF_MASK_ALPHA);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_RED: begin
          cfg.src_mask[0] <= cfg_data;
          cfg.src[0]      <= wr_shift;
        end
        REG_SRC_GREEN: begin
          cfg.src_mask[1] <= cfg_data;
          cfg.src[1]      <= wr_shift;
        end
        REG_SRC_BLUE: begin
          cfg.src_mask[2] <= cfg_data;
          cfg.src[2]      <= wr_shift;
        end
        REG_SRC_ALPHA: begin
          cfg.src_mask[3] <= cfg_data;
          cfg.src[3]      <= wr_shift;
        end
        REG_DST_RED:   cfg.dst[0] <= wr_shift;
        REG_DST_GREEN: cfg.dst[1] <= wr_shift;
        REG_DST_BLUE:  cfg.dst[2] <= wr_shift;
        REG_DST_ALPHA: cfg.dst[3] <= wr_shift;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/cmpc_extract.sv =====
// Input register and channel extraction stage: mask, shift down, left-align.
module cmpc_extract (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_pixel,
  input  logic           in_mode,
  input  cmpc_pkg::cfg_t cfg,
  output logic           ext_valid,
  output cmpc_pkg::ext_t ext,
  input  logic           ext_ready
);
  import cmpc_pkg::*;

  logic        hold_valid;
  logic [31:0] hold_pixel;
  logic        hold_mode;
  logic        advance;
  ext_t        ext_next;

  assign advance  = !ext_valid || ext_ready;
  assign in_ready = !hold_valid || advance;

  always_comb begin
    ext_next.mode = hold_mode;
    for (int c = 0; c < NUM_CHAN; c++) begin
      ext_next.chan[c] = ((hold_pixel & cfg.src_mask[c]) >> cfg.src[c].pos)
                         << cfg.src[c].shortfall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      ext_valid  <= 1'b0;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (advance)  ext_valid  <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_pixel <= in_pixel;
      hold_mode  <= in_mode;
    end
    if (advance && hold_valid) ext <= ext_next;
  end

endmodule

// ===== src/cmpc_place.sv =====
// Alpha inversion, destination placement, channel sum and output register.
module cmpc_place (
  input  logic           clk,
  input  logic           rst,
  input  logic           ext_valid,
  output logic           ext_ready,
  input  cmpc_pkg::ext_t ext,
  input  cmpc_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_pixel
);
  import cmpc_pkg::*;

  logic [31:0] sum_next;
  logic [31:0] v;

  assign ext_ready = !out_valid || out_ready;

  always_comb begin
    sum_next = '0;
    v        = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      v = ext.chan[c];
      if (c == CHAN_ALPHA && ext.mode) v = ALPHA_MAX - v;
      v = (v >> cfg.dst[c].shortfall) << cfg.dst[c].pos;
      sum_next = sum_next + v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ext_ready) begin
      out_valid <= ext_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ext_valid && ext_ready) out_pixel <= sum_next;
  end

endmodule

// ===== src/channel_mask_pixel_converter.sv =====
// Top level of the channel mask pixel converter.
// Converts 32-bit pixels between two layouts, each given by four channel masks.
// Input channel s_axis: tdata carries the source pixel, tuser the alpha mode
// (1 inverts alpha as 255 minus value). Output channel m_axis: tdata carries
// the converted pixel, one output transaction per input transaction, in order.
// Masks are written through cfg_we/cfg_index/cfg_data (index 0..3 source red,
// green, blue, alpha; 4..7 destination); write them only while no pixel is in
// flight. Positions and shortfalls are decoded as the mask is written.
// An accepted pixel passes the input register, the extract register and the
// output register in that order before m_axis_tvalid rises. Throughput: one
// pixel per cycle; the three registers each advance when the stage after them
// is empty or moving.
// Reset empties the pipeline and loads the 8-bit RGBA masks (red lowest).
// When the receiver stalls, the output holds and up to two further pixels
// are taken before s_axis_tready drops.
module channel_mask_pixel_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pixel_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cmpc_pkg::*;

  cfg_t cfg;
  logic ext_valid;
  logic ext_ready;
  ext_t ext;

  cmpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (reg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cmpc_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pixel  (s_axis_tdata),
    .in_mode   (s_axis_tuser),
    .cfg       (cfg),
    .ext_valid (ext_valid),
    .ext       (ext),
    .ext_ready (ext_ready)
  );

  cmpc_place u_place (
    .clk       (clk),
    .rst       (rst),
    .ext_valid (ext_valid),
    .ext_ready (ext_ready),
    .ext       (ext),
    .cfg       (cfg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (m_axis_tdata)
  );

`include "channel_mask_pixel_converter_assert.svh"

  `CMPC_ASSERT_NEXT(a_latency, clk, rst,
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready,
    m_axis_tvalid, "pixel did not reach output in three cycles")

  `CMPC_ASSERT_IMPL(a_ready_when_empty, clk, rst, !ext_valid, s_axis_tready,
    "input stalled with empty extract stage")

  `CMPC_ASSERT_NEXT(a_zero_mask, clk, rst,
    cfg_we && cfg_index == REG_SRC_RED && cfg_data == '0,
    cfg.src[0].pos == '0 && cfg.src[0].shortfall == 4'(FULL_WIDTH),
    "zero mask decoded wrongly")

endmodule

// ===== verif/channel_mask_pixel_converter_tb.sv =====
// Self-checking testbench for the channel mask pixel converter.
`timescale 1ns / 1ps

module channel_mask_pixel_converter_tb;
  import cmpc_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam int RAND_PHASES  = 12;

  // expected converted pixels, in order, plus the layout they were computed with
  class conv_board;
    logic [31:0] src_m [NUM_CHAN];
    logic [31:0] dst_m [NUM_CHAN];
    logic [31:0] pixel_q [$];
    int          errors;

    function new();
      src_m = '{DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA};
      dst_m = '{DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA};
      errors = 0;
    endfunction

    function void set_mask(reg_index_t idx, logic [31:0] val);
      if (idx < REG_DST_RED) begin
        src_m[idx] = val;
      end else begin
        dst_m[idx - REG_DST_RED] = val;
      end
    endfunction

    // lowest set bit, and 8 minus span clamped at 0; empty mask -> 0 / 8
    function void mask_shift(input logic [31:0] m, output int unsigned pos,
                             output int unsigned sf);
      int unsigned lo;
      int unsigned hi;
      lo = 0;
      hi = 0;
      for (int i = 31; i >= 0; i--) if (m[i]) lo = i;
      for (int i = 0; i < 32; i++) if (m[i]) hi = i;
      pos = lo;
      if (m == '0) sf = FULL_WIDTH;
      else if (hi - lo + 1 >= FULL_WIDTH) sf = 0;
      else sf = FULL_WIDTH - (hi - lo + 1);
    endfunction

    function logic [31:0] convert(logic [31:0] pix, logic mode);
      logic [31:0] sum;
      logic [31:0] v;
      int unsigned sp, ss, dp, ds;
      sum = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        mask_shift(src_m[c], sp, ss);
        mask_shift(dst_m[c], dp, ds);
        v = (pix & src_m[c]) >> sp;
        v = v << ss;
        if (c == CHAN_ALPHA && mode) v = ALPHA_MAX - v;
        v = v >> ds;
        v = v << dp;
        sum = sum + v;
      end
      return sum;
    endfunction

    function void note_input(logic [31:0] pix, logic mode);
      pixel_q.push_back(convert(pix, mode));
    endfunction

    function void check_output(logic [31:0] actual);
      logic [31:0] exp_pix;
      if (pixel_q.size() == 0) begin
        $error("unexpected output transaction: pixel_out actual 0x%08h", actual);
        errors++;
      end else begin
        exp_pix = pixel_q.pop_front();
        if (actual !== exp_pix) begin
          $error("pixel_out mismatch: expected 0x%08h actual 0x%08h", exp_pix, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  conv_board board = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  channel_mask_pixel_converter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** channel_mask_pixel_converter: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_mask(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layout(logic [0:7][31:0] m);
    for (int i = 0; i < 8; i++) write_reg(reg_index_t'(i), m[i]);
  endtask

  task automatic send_pixel(logic [31:0] pix, logic mode);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(pix, mode);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_mask();
    int unsigned w;
    int unsigned p;
    logic [63:0] run;
    w = $urandom_range(1, 12);
    p = $urandom_range(0, 31);
    run = ((64'd1 << w) - 64'd1) << p;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 32'd1 << p;
      3, 4: return run[31:0];
      default: return $urandom;
    endcase
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    wait (rst == 1'b0);
    forever begin
      if (rx_count == HOLD_AT) gap = HOLD_CYCLES;
      else gap = rx_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      board.check_output(m_axis_tdata);
      rx_count++;
      if (rx_count % 64 == 0) rx_quiet = $urandom_range(0, 1);
    end
  end

  initial begin
    logic [0:7][31:0] lay;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset layout, field extremes and both modes
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'h5555_5555, 1'b1);
    send_pixel(32'h8000_0001, 1'b1);
    send_pixel(32'h12345678, 1'b0);
    drain();

    // channel swap on the output side
    set_layout({DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA,
                DEF_MASK_BLUE, DEF_MASK_GREEN, DEF_MASK_RED, DEF_MASK_ALPHA});
    send_pixel(32'h11223344, 1'b0);
    send_pixel(32'h80FF_0001, 1'b1);
    drain();

    // narrow 5-6-5 source without alpha: zero mask
    set_layout({32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0,
                DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA});
    send_pixel(32'h0000_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_A5C3, 1'b0);
    drain();

    // wide spans, wide alpha inversion, overlapping destinations
    set_layout({32'hFFFF_FFFF, 32'h0, 32'h0FFF_0000, 32'hFFFF_0000,
                32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_FF00});
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'h0001_0000, 1'b1);
    send_pixel(32'hDEAD_BEEF, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b1);
    drain();

    // single-bit extremes
    set_layout({32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0000_0001});
    send_pixel(32'h8000_0001, 1'b0);
    send_pixel(32'h8000_0001, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int i = 0; i < 8; i++) lay[i] = rand_mask();
      if (ph == RAND_PHASES - 1) begin
        lay = {DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA,
               DEF_MASK_RED, DEF_MASK_GREEN, DEF_MASK_BLUE, DEF_MASK_ALPHA};
      end
      set_layout(lay);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) tx_quiet = $urandom_range(0, 1);
        send_pixel($urandom, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** channel_mask_pixel_converter: PASSED **");
    end else begin
      $display("** channel_mask_pixel_converter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== channel_mask_pixel_converter.f =====
+incdir+src
src/cmpc_pkg.sv
src/cmpc_cfg.sv
src/cmpc_extract.sv
src/cmpc_place.sv
src/channel_mask_pixel_converter.sv
verif/channel_mask_pixel_converter_tb.sv
